FILE: rtl/core/sitoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_pkg
// shared widths, character codes and queue entry types for the signed
// integer to decimal text converter
// ----------------------------------------------------------------------------
package sitoa_pkg;

    localparam int VAL_W         = 32;
    localparam int DIGITS        = 10;
    localparam int BCD_W         = DIGITS * 4;
    localparam int POS_W         = $clog2(DIGITS);
    localparam int BITS_PER_STEP = 4;
    localparam int STEPS         = VAL_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(STEPS);
    localparam int CHAR_W        = 8;
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    typedef logic [BCD_W-1:0] t_bcd;

    // one converted number waiting for the back end
    typedef struct packed {
        logic neg;
        t_bcd bcd;
    } t_entry;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

FILE: rtl/core/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// converts a signed 32-bit integer into its decimal ascii text, sign first,
// most significant digit first, last byte flagged
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         i_valid / o_ready    i_value[31:0] signed
//  text      out        o_valid / i_ready    o_character[7:0], o_last
//
//  front end accepts a request, then runs 8 steps of the shift-and-add-3
//  loop at 4 bits per step; the last step pushes if the queue is not full
//  back end sends a text of n bytes (1..11): it pops the queue, then sends
//  one byte per cycle out of the output register while it is not stalled
//  sustained rate is set by the slower of the two
//  reset is synchronous, active low, and clears only control state
//  a stalled output holds its byte; the 2-entry queue lets the front keep
//  converting, and the front holds its result when the queue is full
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
    import sitoa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_character,
    output logic                    o_last
);

    // front to queue
    logic       push;
    t_entry     push_data;
    // queue to back
    logic       pop;
    t_entry     head;
    t_q_status  q_status;

    // sign split and binary to bcd conversion
    sitoa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // decouples conversion from byte output
    sitoa_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_rd_data   (head),
        .o_status    (q_status)
    );

    // byte sequencer with registered output
    sitoa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // only a minus sign or a decimal digit ever leaves the block
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_character == CHAR_MINUS) ||
                     ((o_character >= CHAR_ZERO) && (o_character <= CHAR_NINE))))
        else $error("illegal output character");

    // a text never ends on its sign
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_character == CHAR_MINUS)) |-> !o_last)
        else $error("minus sign flagged as last");

    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: rtl/core/sitoa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_queue
// two-entry queue of converted numbers between front and back end
// ----------------------------------------------------------------------------
module sitoa_queue
    import sitoa_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_entry    i_push_data,
    input  wire logic      i_pop,
    output t_entry         o_rd_data,
    output t_q_status      o_status
);

    t_entry              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_PTR_W:0]    r_count;
    logic [Q_PTR_W:0]    n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_rd_data      = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule
`default_nettype wire

FILE: rtl/core/sitoa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_front
// takes requests, splits off the sign and turns the magnitude into bcd
// with a shift-and-add-3 loop, four bits per cycle
// ----------------------------------------------------------------------------
module sitoa_front
    import sitoa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [VAL_W-1:0]  i_value,
    input  wire t_q_status         i_q_status,
    output logic                   o_push,
    output t_entry                 o_push_data
);

    localparam logic [1:0] FR_IDLE = 2'd0;
    localparam logic [1:0] FR_CONV = 2'd1;
    localparam logic [1:0] FR_HOLD = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [VAL_W-1:0]  r_bin;
    t_bcd              r_bcd;
    t_bcd              n_bcd;
    logic              r_neg;
    logic [VAL_W-1:0]  mag;
    t_bcd              step_bcd;
    logic              last_step;
    logic              accept;

    // four dependent add-3/shift steps on the ten bcd digits
    function automatic t_bcd f_dd_step(input t_bcd bcd_in,
                                       input logic [BITS_PER_STEP-1:0] bits);
        t_bcd b;
        b = bcd_in;
        for (int s = BITS_PER_STEP - 1; s >= 0; s--) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (b[d*4 +: 4] >= 4'd5) begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], bits[s]};
        end
        return b;
    endfunction

    assign mag       = i_value[VAL_W-1] ? (~i_value + 1'b1) : i_value;
    assign step_bcd  = f_dd_step(r_bcd, r_bin[VAL_W-1 -: BITS_PER_STEP]);
    assign last_step = (r_cnt == CNT_W'(STEPS - 1));
    assign o_ready   = (r_state == FR_IDLE);
    assign accept    = i_valid && o_ready;

    assign o_push = !i_q_status.full &&
                    (((r_state == FR_CONV) && last_step) || (r_state == FR_HOLD));
    assign o_push_data.neg = r_neg;
    assign o_push_data.bcd = (r_state == FR_HOLD) ? r_bcd : step_bcd;

    always_comb begin
        n_state = r_state;
        n_bcd   = r_bcd;
        unique case (r_state)
            FR_IDLE: begin
                if (accept) begin
                    n_state = FR_CONV;
                    n_bcd   = '0;
                end
            end
            FR_CONV: begin
                n_bcd = step_bcd;
                if (last_step) begin
                    n_state = i_q_status.full ? FR_HOLD : FR_IDLE;
                end
            end
            FR_HOLD: begin
                if (!i_q_status.full) begin
                    n_state = FR_IDLE;
                end
            end
            default: begin
                n_state = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= '0;
            end else if (r_state == FR_CONV) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        if (accept) begin
            r_bin <= mag;
            r_neg <= i_value[VAL_W-1];
        end else if (r_state == FR_CONV) begin
            r_bin <= r_bin << BITS_PER_STEP;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sitoa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_back
// pops converted numbers and sends sign and digits one byte per cycle, while
// the output is not stalled, through a registered output stage
// ----------------------------------------------------------------------------
module sitoa_back
    import sitoa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_entry             i_entry,
    input  wire t_q_status          i_q_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [CHAR_W-1:0]       o_character,
    output logic                    o_last
);

    logic               r_active;
    logic               r_sign;
    logic [POS_W-1:0]   r_pos;
    t_bcd               r_bcd;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic [POS_W-1:0]   lead;
    logic               adv;
    logic [3:0]         digit;

    // position of the leading nonzero digit, zero when all digits are zero
    always_comb begin
        lead = '0;
        for (int d = 0; d < DIGITS; d++) begin
            if (i_entry.bcd[d*4 +: 4] != 4'd0) begin
                lead = POS_W'(d);
            end
        end
    end

    assign o_pop = !r_active && !i_q_status.empty;
    assign adv   = r_active && (!r_out_valid || i_ready);
    assign digit = r_bcd[r_pos*4 +: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (adv && !r_sign && (r_pos == '0)) begin
                r_active <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bcd  <= i_entry.bcd;
            r_sign <= i_entry.neg;
            r_pos  <= lead;
        end else if (adv) begin
            if (r_sign) begin
                r_sign <= 1'b0;
            end else if (r_pos != '0) begin
                r_pos <= r_pos - 1'b1;
            end
        end
        if (adv) begin
            if (r_sign) begin
                r_char <= CHAR_MINUS;
                r_last <= 1'b0;
            end else begin
                r_char <= CHAR_ZERO + {4'd0, digit};
                r_last <= (r_pos == '0);
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule
`default_nettype wire
